// File: rtl/core/c_subset_lexer_top_defines.svh
// Assertion macros used by the lexer's checker module.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef C_SUBSET_LEXER_TOP_DEFINES_SVH
`define C_SUBSET_LEXER_TOP_DEFINES_SVH

// Implication in the same cycle.
`define LXR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define LXR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/lxr_pkg.sv
// Package for the C subset lexer: token and scan mode codes, character constants,
// the operator table and the token record types. No dependencies.
package lxr_pkg;

	localparam int KIND_W = 6;
	localparam int TPOS_W = 20;
	localparam int TLEN_W = 20;
	localparam logic [TLEN_W-1:0] LEN_MAX = '1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int OP_COUNT = 9;
	localparam int OP_IDX_W = $clog2(OP_COUNT);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_NONE   = 8'h00;

	typedef enum logic [KIND_W-1:0] {
		K_EOF, K_ILLEGAL, K_IDENT, K_INT, K_CHAR, K_STRING, K_PERIOD, K_ELLIPSIS,
		K_DIV, K_DIV_ASSIGN, K_LPAREN, K_RPAREN, K_COMMA, K_COLON, K_SEMICOLON,
		K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE, K_NOT, K_NOT_EQUAL, K_AND,
		K_AND_ASSIGN, K_LAND, K_MUL, K_MUL_ASSIGN, K_ADD, K_ADD_ASSIGN, K_INC,
		K_SUB, K_SUB_ASSIGN, K_DEC, K_LT, K_LT_EQUAL, K_ASSIGN, K_EQUAL, K_GT,
		K_GT_EQUAL, K_OR, K_OR_ASSIGN, K_LOR
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_CHR, M_STR, M_DOT1, M_DOT2, M_SLASH, M_COMMENT, M_OP
	} mode_t;

	// One operator byte: its plain form, its form with '=' and an optional doubling.
	typedef struct packed {
		logic [7:0] ch;
		kind_t      plain;
		kind_t      with_eq;
		logic [7:0] twin;
		kind_t      doubled;
	} op_entry_t;

	localparam op_entry_t OP_TABLE [OP_COUNT] = '{
		'{8'h21, K_NOT, K_NOT_EQUAL, CH_NONE, K_EOF},
		'{8'h26, K_AND, K_AND_ASSIGN, 8'h26, K_LAND},
		'{8'h2A, K_MUL, K_MUL_ASSIGN, CH_NONE, K_EOF},
		'{8'h2B, K_ADD, K_ADD_ASSIGN, 8'h2B, K_INC},
		'{8'h2D, K_SUB, K_SUB_ASSIGN, 8'h2D, K_DEC},
		'{8'h3C, K_LT, K_LT_EQUAL, CH_NONE, K_EOF},
		'{8'h3D, K_ASSIGN, K_EQUAL, CH_NONE, K_EOF},
		'{8'h3E, K_GT, K_GT_EQUAL, CH_NONE, K_EOF},
		'{8'h7C, K_OR, K_OR_ASSIGN, 8'h7C, K_LOR}
	};

	typedef struct packed {
		logic                hit;
		logic [OP_IDX_W-1:0] idx;
	} op_hit_t;

	// One result beat.
	typedef struct packed {
		kind_t             kind;
		logic [TPOS_W-1:0] start;
		logic [TLEN_W-1:0] len;
		logic              last;
	} token_t;

	// Tokens produced by one source byte, in output order.
	typedef struct packed {
		logic [1:0] cnt;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	function automatic logic is_alpha(logic [7:0] b);
		return b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
	endfunction

	function automatic logic is_numeral(logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic op_hit_t op_lookup(logic [7:0] b);
		op_hit_t r;
		r = '0;
		for (int i = 0; i < OP_COUNT; i++) begin
			if (OP_TABLE[i].ch == b) begin
				r.hit = 1'b1;
				r.idx = OP_IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/lxr_intf.sv
// Stream interfaces of the lexer: the source byte channel and the token channel.
// Depends on lxr_pkg for field widths.
interface lxr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_byte;

	modport source (output valid, output src_byte, input ready);
	modport sink (input valid, input src_byte, output ready);
endinterface

interface lxr_tok_if;
	import lxr_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TPOS_W-1:0] token_start;
	logic [TLEN_W-1:0] token_length;
	logic              last_of_input;

	modport source (output valid, output kind, output token_start, output token_length,
		output last_of_input, input ready);
	modport sink (input valid, input kind, input token_start, input token_length,
		input last_of_input, output ready);
endinterface

// File: rtl/core/lxr_scan.sv
// Scanner core: input byte register, scan mode state and the token decode.
// Depends on lxr_pkg.
module lxr_scan #(
	parameter int POSITION_BITS = 20
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_byte,
	output logic           in_ready,
	input  logic           room2,
	output lxr_pkg::push_t push
);
	import lxr_pkg::*;

	typedef struct packed {
		logic                emit;
		kind_t               kind;
		logic                len1;
		mode_t               mode;
		logic                start_tok;
		logic                set_op;
		logic [OP_IDX_W-1:0] op_idx;
		logic                eof;
	} idle_t;

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	mode_t                    mode_q, mode_d;
	logic                     esc_q, esc_d;
	logic [OP_IDX_W-1:0]      pend_q, pend_d;
	logic [POSITION_BITS-1:0] start_q, start_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [TLEN_W-1:0]        run_q, run_d;

	logic              consume;
	logic [7:0]        b;
	idle_t             ir;
	op_hit_t           oph;
	op_entry_t         op;
	logic [7:0]        quote;
	logic [TLEN_W-1:0] run_inc;
	logic              fe;
	logic              ie;
	logic              use_idle;
	kind_t             fk;
	logic [TLEN_W-1:0] fl;
	token_t            first_tok;
	token_t            idle_tok;

	assign b        = byte_s1;
	assign consume  = valid_s1 && room2;
	assign in_ready = !valid_s1 || consume;
	assign run_inc  = (run_q == LEN_MAX) ? run_q : run_q + TLEN_W'(1);
	assign quote    = (mode_q == M_CHR) ? CH_SQUOTE : CH_DQUOTE;
	assign op       = OP_TABLE[(pend_q < OP_IDX_W'(OP_COUNT)) ? pend_q : '0];
	assign oph      = op_lookup(b);

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Handling of a byte that arrives between tokens.
	always_comb begin
		ir      = '0;
		ir.mode = M_IDLE;
		ir.kind = K_ILLEGAL;
		if (b == CH_SP || b == CH_NL || b == CH_TAB) begin
			ir.mode = M_IDLE;
		end else if (b == CH_NUL) begin
			ir.emit = 1'b1;
			ir.kind = K_EOF;
			ir.eof  = 1'b1;
		end else if (is_alpha(b)) begin
			ir.mode      = M_IDENT;
			ir.start_tok = 1'b1;
		end else if (is_numeral(b)) begin
			ir.mode      = M_NUM;
			ir.start_tok = 1'b1;
		end else if (b == CH_SQUOTE) begin
			ir.mode      = M_CHR;
			ir.start_tok = 1'b1;
		end else if (b == CH_DQUOTE) begin
			ir.mode      = M_STR;
			ir.start_tok = 1'b1;
		end else if (b == CH_DOT) begin
			ir.mode      = M_DOT1;
			ir.start_tok = 1'b1;
		end else if (b == CH_SLASH) begin
			ir.mode      = M_SLASH;
			ir.start_tok = 1'b1;
		end else if (b == CH_HASH) begin
			ir.mode = M_COMMENT;
		end else begin
			ir.emit = 1'b1;
			ir.len1 = 1'b1;
			case (b)
				8'h28: ir.kind = K_LPAREN;
				8'h29: ir.kind = K_RPAREN;
				8'h2C: ir.kind = K_COMMA;
				8'h3A: ir.kind = K_COLON;
				8'h3B: ir.kind = K_SEMICOLON;
				8'h5B: ir.kind = K_LBRACK;
				8'h5D: ir.kind = K_RBRACK;
				8'h7B: ir.kind = K_LBRACE;
				8'h7D: ir.kind = K_RBRACE;
				default: begin
					if (oph.hit) begin
						ir.emit      = 1'b0;
						ir.mode      = M_OP;
						ir.start_tok = 1'b1;
						ir.set_op    = 1'b1;
						ir.op_idx    = oph.idx;
					end else begin
						ir.kind = K_ILLEGAL;
					end
				end
			endcase
		end
	end

	// Token that the current byte closes, and whether the byte then starts afresh.
	always_comb begin
		fe       = 1'b0;
		fk       = K_ILLEGAL;
		fl       = '0;
		use_idle = 1'b0;
		case (mode_q)
			M_IDENT: begin
				if (!(is_alpha(b) || is_numeral(b))) begin
					fe       = 1'b1;
					fk       = K_IDENT;
					fl       = run_q;
					use_idle = 1'b1;
				end
			end
			M_NUM: begin
				if (!is_numeral(b)) begin
					fe       = 1'b1;
					fk       = K_INT;
					fl       = run_q;
					use_idle = 1'b1;
				end
			end
			M_CHR, M_STR: begin
				if (b == CH_NUL) begin
					fe       = 1'b1;
					fk       = K_ILLEGAL;
					fl       = run_q;
					use_idle = 1'b1;
				end else if (b == quote && !esc_q) begin
					fe = 1'b1;
					fk = (mode_q == M_CHR) ? K_CHAR : K_STRING;
					fl = run_inc;
				end
			end
			M_DOT1: begin
				if (b != CH_DOT) begin
					fe       = 1'b1;
					fk       = K_PERIOD;
					fl       = TLEN_W'(1);
					use_idle = 1'b1;
				end
			end
			M_DOT2: begin
				fe = 1'b1;
				if (b == CH_DOT) begin
					fk = K_ELLIPSIS;
					fl = TLEN_W'(3);
				end else begin
					fk       = K_ILLEGAL;
					fl       = TLEN_W'(2);
					use_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (b == CH_EQ) begin
					fe = 1'b1;
					fk = K_DIV_ASSIGN;
					fl = TLEN_W'(2);
				end else if (b != CH_SLASH) begin
					fe       = 1'b1;
					fk       = K_DIV;
					fl       = TLEN_W'(1);
					use_idle = 1'b1;
				end
			end
			M_COMMENT: begin
				use_idle = (b == CH_NUL);
			end
			M_OP: begin
				fe = 1'b1;
				if (b == CH_EQ) begin
					fk = op.with_eq;
					fl = TLEN_W'(2);
				end else if (op.twin != CH_NONE && b == op.twin) begin
					fk = op.doubled;
					fl = TLEN_W'(2);
				end else begin
					fk       = op.plain;
					fl       = TLEN_W'(1);
					use_idle = 1'b1;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase
	end

	// Order the tokens of this byte; the last one carries the end flag.
	always_comb begin
		ie              = use_idle && ir.emit;
		first_tok.kind  = fk;
		first_tok.start = TPOS_W'(start_q);
		first_tok.len   = fl;
		first_tok.last  = !ie;
		idle_tok.kind   = ir.kind;
		idle_tok.start  = TPOS_W'(pos_q);
		idle_tok.len    = TLEN_W'(ir.len1);
		idle_tok.last   = 1'b1;
		push.tok0       = fe ? first_tok : idle_tok;
		push.tok1       = idle_tok;
		push.cnt        = consume ? (2'(fe) + 2'(ie)) : 2'd0;
	end

	// Next scan state.
	always_comb begin
		mode_d  = mode_q;
		esc_d   = esc_q;
		pend_d  = pend_q;
		start_d = start_q;
		run_d   = run_q;
		pos_d   = pos_q + POSITION_BITS'(1);
		case (mode_q)
			M_IDENT, M_NUM: begin
				if (!use_idle) begin
					run_d = run_inc;
				end
			end
			M_CHR, M_STR: begin
				if (b != CH_NUL) begin
					run_d = run_inc;
					if (fe) begin
						mode_d = M_IDLE;
						esc_d  = 1'b0;
					end else begin
						esc_d = (b == CH_BSLASH) && !esc_q;
					end
				end
			end
			M_DOT1: begin
				if (!use_idle) begin
					mode_d = M_DOT2;
					run_d  = TLEN_W'(2);
				end
			end
			M_SLASH: begin
				if (b == CH_SLASH) begin
					mode_d = M_COMMENT;
				end else if (!use_idle) begin
					mode_d = M_IDLE;
				end
			end
			M_COMMENT: begin
				if (b == CH_NL) begin
					mode_d = M_IDLE;
				end
			end
			M_DOT2, M_OP: begin
				if (!use_idle) begin
					mode_d = M_IDLE;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		if (use_idle) begin
			mode_d = ir.mode;
			esc_d  = 1'b0;
			if (ir.start_tok) begin
				start_d = pos_q;
				run_d   = TLEN_W'(1);
			end
			if (ir.set_op) begin
				pend_d = ir.op_idx;
			end
			// End of input returns everything to the reset state.
			if (ir.eof) begin
				mode_d  = M_IDLE;
				esc_d   = 1'b0;
				pend_d  = '0;
				start_d = '0;
				pos_d   = '0;
				run_d   = '0;
			end
		end
	end

	// Scan state registers, advanced once per consumed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			esc_q   <= 1'b0;
			pend_q  <= '0;
			start_q <= '0;
			pos_q   <= '0;
			run_q   <= '0;
		end else if (consume) begin
			mode_q  <= mode_d;
			esc_q   <= esc_d;
			pend_q  <= pend_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			run_q   <= run_d;
		end
	end

endmodule

// File: rtl/core/lxr_tok_fifo.sv
// Token output queue: takes up to two tokens per cycle and hands out one per beat.
// Depends on lxr_pkg.
module lxr_tok_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  lxr_pkg::push_t  push,
	input  logic            pop,
	output logic            room2,
	output logic            out_valid,
	output lxr_pkg::token_t out_tok
);
	import lxr_pkg::*;

	token_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] wr_nxt;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	assign out_valid = (cnt_q != '0);
	assign out_tok   = mem_q[rd_q];
	assign room2     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
	assign do_pop    = pop && out_valid;
	assign wr_nxt    = wr_q + FIFO_PTR_W'(1);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_nxt] <= push.tok1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_W'(push.cnt);
			rd_q  <= rd_q + FIFO_PTR_W'(do_pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(do_pop);
		end
	end

endmodule

// File: rtl/core/c_subset_lexer_top.sv
// Streaming C subset lexer: one source byte in per beat, token records out per beat.
// Input channel in_ch carries src_byte; output channel out_ch carries kind, token_start,
// token_length and last_of_input. A byte 0 ends the input with an EOF token.
// A token is known only when the byte after it arrives, so each byte yields zero,
// one or two tokens. An accepted byte passes an input register, then the decode
// writes its tokens into a four-entry token queue, which out_ch reads. Bytes are
// taken at one per clock as long as the queue has room for two tokens, so a
// steady stream runs at one byte per cycle; the output side delivers one token
// per cycle while out_ch is ready, which bounds the rate when bytes produce two
// tokens each. When out_ch is stalled the queue fills; once it holds three or
// more tokens the byte in the input register waits and in_ch.ready drops until
// a token leaves. Nothing is lost. Reset clears the scan state, the position
// counter and the queue; the first byte after reset, or after an EOF, is at
// position 0.
// Depends on lxr_pkg, lxr_intf, lxr_scan and lxr_tok_fifo.
module c_subset_lexer_top #(
	parameter int POSITION_BITS = 20
) (
	input logic       clk,
	input logic       arst_n,
	lxr_byte_if.sink  in_ch,
	lxr_tok_if.source out_ch
);
	import lxr_pkg::*;

	push_t  push;
	logic   room2;
	logic   out_valid;
	token_t out_tok;

	// Byte register and scan decode.
	lxr_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_byte (in_ch.src_byte),
		.in_ready(in_ch.ready),
		.room2   (room2),
		.push    (push)
	);

	// Token queue toward the output channel.
	lxr_tok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (out_ch.ready),
		.room2    (room2),
		.out_valid(out_valid),
		.out_tok  (out_tok)
	);

	assign out_ch.valid         = out_valid;
	assign out_ch.kind          = out_tok.kind;
	assign out_ch.token_start   = out_tok.start;
	assign out_ch.token_length  = out_tok.len;
	assign out_ch.last_of_input = out_tok.last;

endmodule

// File: rtl/core/lxr_chk.sv
// Port-level checker for the lexer's token channel, bound to the top level.
// Depends on lxr_pkg and c_subset_lexer_top_defines.svh.
`include "c_subset_lexer_top_defines.svh"

module lxr_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [lxr_pkg::KIND_W-1:0] out_kind,
	input logic [lxr_pkg::TPOS_W-1:0] out_start,
	input logic [lxr_pkg::TLEN_W-1:0] out_len,
	input logic                      out_last
);
	import lxr_pkg::*;

	// A stalled token beat keeps its contents.
	`LXR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_start) && $stable(out_len) && $stable(out_last), "token changed while stalled")

	// The first token of a pair is followed at once by its partner, which ends the pair.
	`LXR_ASSERT_NEXT(a_pair_follows, out_valid && out_ready && !out_last, out_valid && out_last, "second token of a pair missing")

	// End of input is always the final token of its byte and has no length.
	`LXR_ASSERT_SAME(a_eof_shape, out_valid && out_kind == K_EOF, out_last && out_len == '0, "malformed EOF token")

endmodule

bind c_subset_lexer_top lxr_chk u_lxr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_kind (out_ch.kind),
	.out_start(out_ch.token_start),
	.out_len  (out_ch.token_length),
	.out_last (out_ch.last_of_input)
);
